[rtl/bf3_pkg.sv]
// Shared types and constants of the streaming 3x3 box filter.
package bf3_pkg;

  // Fixed field widths of the stream, row limit and reset dimension
  localparam int SAMPLE_BITS = 16;
  localparam int COL_W       = 10;
  localparam int ROW_W       = 10;
  localparam int DIM_W       = 11;
  localparam int MAX_ROWS    = 1024;
  localparam int RESET_DIM   = 64;

  // Window arithmetic: a column sum of three samples, a window sum of nine plus rounding
  localparam int CS_W   = SAMPLE_BITS + 2;
  localparam int SUM_W  = SAMPLE_BITS + 4;

  // Divide by nine as a multiply by ceil(2^K / 9), exact for every window sum
  localparam int RECIP_SHIFT = SUM_W + 4;
  localparam int RECIP_W     = SUM_W + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd8) / 64'd9);

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [ROW_W-1:0]       row_t;
  typedef logic [CS_W-1:0]        col_sum_t;
  typedef logic [SUM_W-1:0]       win_sum_t;
  typedef logic [PROD_W-1:0]      prod_t;

endpackage

[rtl/box_filter_3x3_stream.sv]
// Streaming 3x3 mean filter over a raster height map, border samples passed through.
//
//  channel  signals                                   direction  request
//  -------  ----------------------------------------  ---------  ----------------------------
//  in       in_valid, in_ready, sample                into       one raster sample
//  out      out_valid, out_ready, value, col, row,    out of     one result; last closes the
//           last                                                 results of one sample
//  cfg      cfg_valid, cfg_ready, cfg_index, cfg_data into       write of frame_width/height
//
// One sample per clock is taken while the input is not stalled; a result passes the line
// memory read, window sum and divide-by-nine multiply registers. A sample with two results
// holds the output stage until both have left, so the input stalls unless a bubble is in
// flight. Reset clears position counters, pipeline valids and column sums and sets both
// dimensions to 64; the line memory is not cleared. Output stalls back up stage by stage.
module box_filter_3x3_stream #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bf3_pkg::SAMPLE_BITS-1:0] sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bf3_pkg::SAMPLE_BITS-1:0] value,
  output logic [bf3_pkg::COL_W-1:0]       col,
  output logic [bf3_pkg::ROW_W-1:0]       row,
  output logic                            last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bf3_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bf3_pkg::DIM_W-1:0]       cfg_data
);

  localparam int AW       = $clog2(MAX_WIDTH);
  localparam int CW       = bf3_pkg::COL_W;
  localparam int RW       = bf3_pkg::ROW_W;
  localparam int SB       = bf3_pkg::SAMPLE_BITS;
  localparam int SW       = bf3_pkg::SUM_W;
  localparam int CSW      = bf3_pkg::CS_W;
  localparam int DW       = bf3_pkg::DIM_W;
  localparam int W_RST    = (bf3_pkg::RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : bf3_pkg::RESET_DIM;
  localparam int H_RST    = (bf3_pkg::RESET_DIM > bf3_pkg::MAX_ROWS) ?
                            bf3_pkg::MAX_ROWS : bf3_pkg::RESET_DIM;

  // Last column and last row indexes, clamped on write
  logic [AW-1:0]   w_last;
  bf3_pkg::row_t   h_last;

  // Position counters
  logic [AW-1:0]   col_count;
  bf3_pkg::row_t   row_count;

  // Stage 1: line memory data arrives
  logic            v1;
  bf3_pkg::sample_t s1;
  logic [AW-1:0]   c1;
  bf3_pkg::row_t   r1;
  logic            f1, b1;
  logic [2*SB-1:0] mem_rd;

  // Window column sums: the column two back and the column one back
  bf3_pkg::col_sum_t cs_two, cs_one;

  // Stage 2: rounded window sum
  logic            v2;
  bf3_pkg::win_sum_t x2;
  bf3_pkg::sample_t s2;
  logic [AW-1:0]   c2;
  bf3_pkg::row_t   r2;
  logic            f2, b2;

  // Stage 3: output stage, pending filtered and pass-through results
  bf3_pkg::prod_t  p3;
  bf3_pkg::sample_t s3;
  logic [AW-1:0]   c3;
  bf3_pkg::row_t   r3;
  logic            f3, b3;

  logic            in_acc;
  logic            free3, can2, can1, move1;
  logic            border0, filt0;
  bf3_pkg::sample_t t1, t2;
  bf3_pkg::col_sum_t col_sum;
  bf3_pkg::win_sum_t win_sum;

  assign cfg_ready = 1'b1;

  // Configuration registers with range clamp
  always_ff @(posedge clk) begin
    if (rst) begin
      w_last <= AW'(W_RST - 1);
      h_last <= RW'(H_RST - 1);
    end else if (cfg_valid) begin
      case (cfg_index)
        bf3_pkg::REG_FRAME_WIDTH: begin
          if (cfg_data < DW'(3)) begin
            w_last <= AW'(2);
          end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
            w_last <= AW'(MAX_WIDTH - 1);
          end else begin
            w_last <= AW'(cfg_data - DW'(1));
          end
        end
        bf3_pkg::REG_FRAME_HEIGHT: begin
          if (cfg_data < DW'(3)) begin
            h_last <= RW'(2);
          end else if (32'(cfg_data) > 32'(bf3_pkg::MAX_ROWS)) begin
            h_last <= RW'(bf3_pkg::MAX_ROWS - 1);
          end else begin
            h_last <= RW'(cfg_data - DW'(1));
          end
        end
        default: begin
          w_last <= w_last;
        end
      endcase
    end
  end

  // Stage handshakes: each stage takes a new entry when empty or when it moves on
  always_comb begin
    free3    = !(f3 || b3) || (out_ready && !(f3 && b3));
    can2     = !v2 || free3;
    can1     = !v1 || can2;
    move1    = v1 && can2;
    in_ready = can1;
    in_acc   = in_valid && can1;
  end

  // Position classification of the arriving sample
  always_comb begin
    border0 = (col_count == '0) || (col_count >= w_last) ||
              (row_count == '0) || (row_count >= h_last);
    filt0   = (col_count >= AW'(2)) && (row_count >= RW'(2)) &&
              (col_count <= w_last) && (row_count <= h_last);
  end

  // Raster counters, wrap at row end and frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_acc) begin
      if (col_count >= w_last) begin
        col_count <= '0;
        row_count <= (row_count >= h_last) ? '0 : row_count + RW'(1);
      end else begin
        col_count <= col_count + AW'(1);
      end
    end
  end

  // Line memory: entry holds {row above, two rows above}
  bf3_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (2 * SB)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_count),
    .rd_data (mem_rd),
    .wr_en   (move1),
    .wr_addr (c1),
    .wr_data ({s1, t1})
  );

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (can1) begin
      v1 <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1 <= sample;
      c1 <= col_count;
      r1 <= row_count;
      f1 <= filt0;
      b1 <= border0;
    end
  end

  // Window sum with rounding constant
  always_comb begin
    t1      = mem_rd[2*SB-1:SB];
    t2      = mem_rd[SB-1:0];
    col_sum = CSW'(t2) + CSW'(t1) + CSW'(s1);
    win_sum = SW'(cs_two) + SW'(cs_one) + SW'(col_sum) + SW'(4);
  end

  // Window column shift, in sample order
  always_ff @(posedge clk) begin
    if (rst) begin
      cs_two <= '0;
      cs_one <= '0;
    end else if (move1) begin
      cs_two <= cs_one;
      cs_one <= col_sum;
    end
  end

  // Stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (can2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (move1) begin
      x2 <= win_sum;
      s2 <= s1;
      c2 <= c1;
      r2 <= r1;
      f2 <= f1;
      b2 <= b1;
    end
  end

  // Stage 3: divide by nine and hold pending results
  always_ff @(posedge clk) begin
    if (rst) begin
      f3 <= 1'b0;
      b3 <= 1'b0;
    end else if (free3) begin
      f3 <= v2 && f2;
      b3 <= v2 && b2;
    end else if (out_ready) begin
      // both pending: filtered result goes first
      f3 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (free3 && v2) begin
      p3 <= bf3_pkg::PROD_W'(x2) * bf3_pkg::PROD_W'(bf3_pkg::RECIP);
      s3 <= s2;
      c3 <= c2;
      r3 <= r2;
    end
  end

  // Result select: filtered window centre first, then pass-through
  always_comb begin
    out_valid = f3 || b3;
    last      = !(f3 && b3);
    if (f3) begin
      value = p3[bf3_pkg::RECIP_SHIFT +: SB];
      col   = CW'(c3 - AW'(1));
      row   = r3 - RW'(1);
    end else begin
      value = s3;
      col   = CW'(c3);
      row   = r3;
    end
  end

endmodule

[rtl/bf3_line_mem.sv]
// Line memory for the two rows above the current one, registered read port.
module bf3_line_mem #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 32
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[tb/box_filter_3x3_stream_tb.sv]
// Self-checking testbench for the streaming 3x3 box filter, with its own window-mean predictor.
`timescale 1ns / 100ps

module box_filter_3x3_stream_tb;

  localparam int MAX_COLS    = 1024;
  localparam int PIPE_SETTLE = 8;     // cycles to flush the pipeline once results stop
  localparam int STALL_LIMIT = 4000;  // cycles without any handshake before giving up
  localparam int HOLD_LONG   = 400;   // receiver hold-off used to fill the block
  localparam int RANDOM_ITEMS = 460;
  localparam int TALL_ROWS   = 40;    // rows sent under a saturated height

  typedef logic [bf3_pkg::COL_W-1:0] col_t;
  typedef logic [bf3_pkg::DIM_W-1:0] dim_t;

  typedef struct packed {
    bf3_pkg::sample_t value;
    col_t             col;
    bf3_pkg::row_t    row;
    logic             last;
  } pixel_t;

  logic              clk;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  bf3_pkg::sample_t  sample    = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  bf3_pkg::sample_t  value;
  col_t              col;
  bf3_pkg::row_t     row;
  logic              last;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  bf3_pkg::cfg_reg_t cfg_index = bf3_pkg::REG_FRAME_WIDTH;
  dim_t              cfg_data  = '0;

  box_filter_3x3_stream #(.MAX_WIDTH(MAX_COLS)) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .col       (col),
    .row       (row),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state: two rows above, window taps, raster position, frame size
  bf3_pkg::sample_t above_row     [MAX_COLS];
  bf3_pkg::sample_t two_above_row [MAX_COLS];
  bf3_pkg::sample_t win_taps      [6];
  int unsigned pred_col;
  int unsigned pred_row;
  dim_t    pred_width;
  dim_t    pred_height;

  pixel_t  due_pixels[$];
  int      faults      = 0;
  int      items_sent  = 0;
  int      hold_cycles = 0;
  bit      send_flat   = 1'b0;
  bit      recv_flat   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Out-of-range dimensions saturate to 3..1024
  function automatic int unsigned eff_dim(dim_t v);
    if (v < 3) return 3;
    if (v > bf3_pkg::MAX_ROWS) return bf3_pkg::MAX_ROWS;
    return 32'(v);
  endfunction

  // One accepted sample: queue the filtered pixel it completes and/or its pass-through
  function automatic void predict_mean(bf3_pkg::sample_t s);
    int unsigned w, h, c, r, sum;
    bf3_pkg::sample_t t1, t2;
    logic    border;
    pixel_t  px;
    w  = eff_dim(pred_width);
    h  = eff_dim(pred_height);
    c  = pred_col;
    r  = pred_row;
    t2 = two_above_row[c];
    t1 = above_row[c];
    border = (c == 0) || (c >= w - 1) || (r == 0) || (r >= h - 1);
    if (c >= 2 && r >= 2 && c <= w - 1 && r <= h - 1) begin
      sum = 32'(win_taps[0]);
      for (int k = 1; k < 6; k++) sum += 32'(win_taps[k]);
      sum += 32'(t1) + 32'(t2) + 32'(s);
      px.value = bf3_pkg::sample_t'((sum + 4) / 9);
      px.col   = col_t'(c - 1);
      px.row   = bf3_pkg::row_t'(r - 1);
      px.last  = !border;
      due_pixels.push_back(px);
    end
    if (border) begin
      px.value = s;
      px.col   = col_t'(c);
      px.row   = bf3_pkg::row_t'(r);
      px.last  = 1'b1;
      due_pixels.push_back(px);
    end
    // shift the window left and roll the line stores
    win_taps[0] = win_taps[3];
    win_taps[1] = win_taps[4];
    win_taps[2] = win_taps[5];
    win_taps[3] = t2;
    win_taps[4] = t1;
    win_taps[5] = s;
    two_above_row[c] = t1;
    above_row[c]     = s;
    // raster position, wrapping at row and frame end
    if (c >= w - 1) begin
      pred_col = 0;
      pred_row = (r >= h - 1) ? 0 : r + 1;
    end else begin
      pred_col = c + 1;
    end
  endfunction

  function automatic void log_fault(string msg);
    faults++;
    if (faults <= 10) $display("%s", msg);
  endfunction

  function automatic bf3_pkg::sample_t pick_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return bf3_pkg::sample_t'($urandom);
    endcase
  endfunction

  // Send one sample request and update the predictor when it is taken
  task automatic send_sample(input bf3_pkg::sample_t s);
    int gap;
    gap = send_flat ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    predict_mean(s);
    items_sent++;
  endtask

  task automatic send_run(input int n);
    for (int i = 0; i < n; i++) send_sample(pick_sample());
  endtask

  // Stop sending, wait for every queued result, then let the pipeline flush
  task automatic settle();
    in_valid <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // Write both frame registers back to back; only called with the block idle
  task automatic program_frame(input dim_t w, input dim_t h);
    cfg_valid <= 1'b1;
    cfg_index <= bf3_pkg::REG_FRAME_WIDTH;
    cfg_data  <= w;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    pred_width = w;
    cfg_index <= bf3_pkg::REG_FRAME_HEIGHT;
    cfg_data  <= h;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    pred_height = h;
    cfg_valid <= 1'b0;
  endtask

  // Reset size is 64: one full row, then finish the frame at 3x3 (low values saturate)
  task automatic test_default_dims();
    send_run(64);
    settle();
    program_frame(dim_t'(1), dim_t'(2));
    send_run(6);
    settle();
  endtask

  // Smallest frame at full scale, then a 4x3 frame where both interior samples give nothing
  task automatic test_smallest_frames();
    program_frame(dim_t'(0), dim_t'(0));
    for (int i = 0; i < 9; i++) send_sample('1);
    settle();
    program_frame(dim_t'(4), dim_t'(3));
    for (int i = 0; i < 12; i++) begin
      case (i % 3)
        0:       send_sample('0);
        1:       send_sample('1);
        default: send_sample(bf3_pkg::sample_t'($urandom));
      endcase
    end
    settle();
  endtask

  // Width saturates at 1024: one full row, then close the frame at 3x3
  task automatic test_widest_row();
    program_frame(dim_t'(1025), dim_t'(2047));
    send_run(MAX_COLS);
    settle();
    program_frame(dim_t'(3), dim_t'(3));
    send_run(6);
    settle();
  endtask

  // Oversized height saturates high: many rows pass with no wrap, then a short height
  // makes the current row the last one
  task automatic test_tallest_frame();
    program_frame(dim_t'(2), dim_t'(2047));
    send_run(3 * TALL_ROWS);
    settle();
    program_frame(dim_t'(2), dim_t'(2));
    send_run(3);
    settle();
  endtask

  // Shrink width with the column counter past the new end, then shrink height past the row
  task automatic test_shrink_mid_frame();
    program_frame(dim_t'(10), dim_t'(8));
    send_run(36);
    settle();
    program_frame(dim_t'(5), dim_t'(8));
    send_run(6);
    settle();
    program_frame(dim_t'(5), dim_t'(4));
    send_run(5);
    settle();
  endtask

  // Receiver holds off while requests keep coming; then a frame with no idling at all
  task automatic test_backpressure();
    program_frame(dim_t'(8), dim_t'(6));
    send_flat   = 1'b1;
    hold_cycles = HOLD_LONG;
    send_run(48);
    send_flat   = 1'b0;
    settle();
    send_flat = 1'b1;
    recv_flat = 1'b1;
    program_frame(dim_t'(7), dim_t'(5));
    send_run(35);
    settle();
    send_flat = 1'b0;
    recv_flat = 1'b0;
  endtask

  // Whole frames of random size and content, mostly small
  task automatic test_random_frames();
    int   goal;
    dim_t w, h;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      case ($urandom_range(0, 9))
        0:       w = dim_t'($urandom_range(0, 2));
        1:       w = dim_t'($urandom_range(13, 40));
        default: w = dim_t'($urandom_range(3, 12));
      endcase
      case ($urandom_range(0, 9))
        0:       h = dim_t'($urandom_range(0, 2));
        1:       h = dim_t'($urandom_range(11, 24));
        default: h = dim_t'($urandom_range(3, 10));
      endcase
      send_flat = ($urandom_range(0, 5) == 0);
      recv_flat = ($urandom_range(0, 5) == 0);
      program_frame(w, h);
      send_run(int'(eff_dim(w) * eff_dim(h)));
      settle();
    end
    send_flat = 1'b0;
    recv_flat = 1'b0;
  endtask

  // Result side: random stalls, long hold on demand, compare against the oldest prediction
  initial begin : result_checker
    int     gap;
    pixel_t want;
    @(negedge rst);
    forever begin
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        gap = recv_flat ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      if (due_pixels.size() == 0) begin
        log_fault($sformatf("unexpected result: value=%0d col=%0d row=%0d last=%0b",
                            value, col, row, last));
      end else begin
        want = due_pixels.pop_front();
        if (value !== want.value || col !== want.col || row !== want.row
            || last !== want.last) begin
          log_fault($sformatf({"mismatch: expected value=%0d col=%0d row=%0d last=%0b,",
                               " got value=%0d col=%0d row=%0d last=%0b"},
                              want.value, want.col, want.row, want.last,
                              value, col, row, last));
        end
      end
      @(posedge clk);
    end
  end

  // Watchdog: too long without any request moving on any channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(negedge rst);
    while (quiet < STALL_LIMIT) begin
      @(negedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
             STALL_LIMIT, due_pixels.size());
    $display("box_filter_3x3_stream verification failed");
    $finish;
  end

  initial begin : test_sequence
    foreach (above_row[i]) begin
      above_row[i]     = '0;
      two_above_row[i] = '0;
    end
    foreach (win_taps[i]) win_taps[i] = '0;
    pred_col    = 0;
    pred_row    = 0;
    pred_width  = dim_t'(bf3_pkg::RESET_DIM);
    pred_height = dim_t'(bf3_pkg::RESET_DIM);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_dims();
    test_smallest_frames();
    test_widest_row();
    test_tallest_frame();
    test_shrink_mid_frame();
    test_backpressure();
    test_random_frames();
    settle();
    repeat (2 * PIPE_SETTLE) @(posedge clk);
    if (faults == 0) begin
      $display("box_filter_3x3_stream verification clean");
    end else begin
      $display("box_filter_3x3_stream verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/bf3_pkg.sv
rtl/bf3_line_mem.sv
rtl/box_filter_3x3_stream.sv
tb/box_filter_3x3_stream_tb.sv
